// ===== src/wppe_pkg.sv =====
`timescale 1ns / 1ps
package wppe_pkg;

	localparam int AC_W = 40;
	localparam int DC_W = 8;
	localparam int D_W = 3;
	localparam int W_W = 11;
	localparam int OFS_W = 8;

	localparam int DEN_W = AC_W + 1;
	// cur_ac << (d + 1) plus ref_ac, d at most 2^D_W - 1
	localparam int NUM_W = AC_W + (1 << D_W) + 1;
	localparam int DIV_STAGES = W_W;
	localparam int PIPE_DEPTH = 2 + DIV_STAGES + 4;

	localparam int PIXEL_BITS_DEF = 8;
	localparam logic [D_W-1:0] LOG2_DENOM_RST = 3'd6;

	localparam int SAT_RATIO = 15;
	localparam int W_MAX = SAT_RATIO << ((1 << D_W) - 1);
	localparam int PRED_BASE = 128;
	localparam int DELTA_MIN = -512;
	localparam int DELTA_MAX = 511;
	localparam int OFS_MIN = -128;
	localparam int OFS_MAX = 127;
	localparam int WD_MIN = -128;
	localparam int WD_MAX = 127;

	typedef struct packed {
		logic is_chroma;
		logic [DC_W-1:0] cur_dc;
		logic [DC_W-1:0] ref_dc;
		logic zero;
		logic sat;
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [W_W-1:0] quo;
	} wppe_div_t;

	typedef struct packed {
		logic valid;
		wppe_div_t data;
	} wppe_div_req_t;

endpackage

// ===== src/wppe_in_if.sv =====
`timescale 1ns / 1ps
interface wppe_in_if import wppe_pkg::*; ();
	logic valid;
	logic ready;
	logic is_chroma;
	logic [DC_W-1:0] cur_dc;
	logic [AC_W-1:0] cur_ac;
	logic [DC_W-1:0] ref_dc;
	logic [AC_W-1:0] ref_ac;

	modport source (output valid, is_chroma, cur_dc, cur_ac, ref_dc, ref_ac, input ready);
	modport sink (input valid, is_chroma, cur_dc, cur_ac, ref_dc, ref_ac, output ready);
endinterface

// ===== src/wppe_out_if.sv =====
`timescale 1ns / 1ps
interface wppe_out_if import wppe_pkg::*; ();
	logic valid;
	logic ready;
	logic [W_W-1:0] weight;
	logic signed [OFS_W-1:0] offset;
	logic weight_in_range;

	modport source (output valid, weight, offset, weight_in_range, input ready);
	modport sink (input valid, weight, offset, weight_in_range, output ready);
endinterface

// ===== src/weighted_pred_param_estimate.sv =====
`timescale 1ns / 1ps
// channel      dir  handshake        payload
// stat         in   valid/ready      is_chroma, cur_dc, cur_ac, ref_dc, ref_ac
// est          out  valid/ready      weight, offset, weight_in_range
// log2_denom   cfg  log2_denom_we    log2_denom_wdata
//
// One request per cycle unless a stall at est has filled every stage; results pass through 17
// register stages (2 prep stages, one stage per quotient bit of the 11-bit
// restoring divider, 4 offset stages).
// Each stage holds its own valid bit; a stall at est backs up stage by stage
// and bubbles collapse, so stat stays ready while any stage is empty.
// Reset clears all valid bits and sets log2_denom to 6.
module weighted_pred_param_estimate import wppe_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic log2_denom_we,
	input logic [D_W-1:0] log2_denom_wdata,
	wppe_in_if.sink stat,
	wppe_out_if.source est
);

	logic [D_W-1:0] log2_denom_q;
	wppe_div_req_t div_req [DIV_STAGES+1];
	logic div_ready [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_denom_q <= LOG2_DENOM_RST;
		end else if (log2_denom_we) begin
			log2_denom_q <= log2_denom_wdata;
		end
	end

	wppe_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.log2_denom(log2_denom_q),
		.stat(stat),
		.dn(div_req[0]),
		.dn_ready(div_ready[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		wppe_div_stage #(
			.BIT(DIV_STAGES - 1 - i)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.up(div_req[i]),
			.up_ready(div_ready[i]),
			.dn(div_req[i+1]),
			.dn_ready(div_ready[i+1])
		);
	end

	wppe_post #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.log2_denom(log2_denom_q),
		.up(div_req[DIV_STAGES]),
		.up_ready(div_ready[DIV_STAGES]),
		.est(est)
	);

endmodule

// ===== src/wppe_prep.sv =====
`timescale 1ns / 1ps
module wppe_prep import wppe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [D_W-1:0] log2_denom,
	wppe_in_if.sink stat,
	output wppe_div_req_t dn,
	input logic dn_ready
);

	logic valid_s1, valid_s2;
	logic ready_s1, ready_s2;
	logic chroma_s1;
	logic [DC_W-1:0] cur_dc_s1, ref_dc_s1;
	logic [AC_W-1:0] cur_ac_s1;
	logic [AC_W+3:0] ref15_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	logic zero_s1;
	wppe_div_t div_s2;

	logic [D_W:0] num_sh;
	logic [NUM_W-1:0] num_c;
	logic [AC_W+3:0] ref15_c;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign stat.ready = ready_s1;

	always_comb begin
		num_sh = {1'b0, log2_denom} + (D_W+1)'(1);
		num_c = (NUM_W'(stat.cur_ac) << num_sh) + NUM_W'(stat.ref_ac);
		ref15_c = {stat.ref_ac, 4'b0000} - (AC_W+4)'(stat.ref_ac);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= stat.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && stat.valid) begin
			chroma_s1 <= stat.is_chroma;
			cur_dc_s1 <= stat.cur_dc;
			ref_dc_s1 <= stat.ref_dc;
			cur_ac_s1 <= stat.cur_ac;
			ref15_s1 <= ref15_c;
			num_s1 <= num_c;
			den_s1 <= {stat.ref_ac, 1'b0};
			zero_s1 <= (stat.ref_ac == '0);
		end
		if (ready_s2 && valid_s1) begin
			div_s2.is_chroma <= chroma_s1;
			div_s2.cur_dc <= cur_dc_s1;
			div_s2.ref_dc <= ref_dc_s1;
			div_s2.zero <= zero_s1;
			div_s2.sat <= ((AC_W+4)'(cur_ac_s1) >= ref15_s1);
			div_s2.rem <= num_s1;
			div_s2.den <= den_s1;
			div_s2.quo <= '0;
		end
	end

	assign dn.valid = valid_s2;
	assign dn.data = div_s2;

endmodule

// ===== src/wppe_div_stage.sv =====
`timescale 1ns / 1ps
module wppe_div_stage import wppe_pkg::*; #(
	parameter int BIT = 0
) (
	input logic clk,
	input logic arst_n,
	input wppe_div_req_t up,
	output logic up_ready,
	output wppe_div_req_t dn,
	input logic dn_ready
);

	localparam int XW = (NUM_W > DEN_W + W_W) ? NUM_W : DEN_W + W_W;

	logic valid_s;
	wppe_div_t data_s;
	wppe_div_t nxt;
	logic [XW-1:0] dsh;
	logic [XW-1:0] rem_x;
	logic take;

	assign up_ready = !valid_s || dn_ready;

	// one restoring step: quotient bit BIT
	always_comb begin
		nxt = up.data;
		dsh = XW'(up.data.den) << BIT;
		rem_x = XW'(up.data.rem);
		take = (rem_x >= dsh);
		if (take) begin
			nxt.rem = NUM_W'(rem_x - dsh);
		end
		nxt.quo[BIT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (up_ready) begin
			valid_s <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			data_s <= nxt;
		end
	end

	assign dn.valid = valid_s;
	assign dn.data = data_s;

endmodule

// ===== src/wppe_post.sv =====
`timescale 1ns / 1ps
module wppe_post import wppe_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [D_W-1:0] log2_denom,
	input wppe_div_req_t up,
	output logic up_ready,
	wppe_out_if.source est
);

	localparam int SH_MAX = (1 << D_W) - 1 + PIXEL_BITS - 8;
	localparam int SH_W = $clog2(SH_MAX + 1);
	localparam int PROD_W = W_W + DC_W;
	localparam int TW = ((PROD_W > SH_MAX) ? PROD_W : SH_MAX) + 2;
	localparam int SCL_W = W_W + 7;
	localparam int PW = SCL_W + 2;
	localparam int DW = ((TW > PW) ? TW : PW) + 1;

	function automatic logic signed [DW-1:0] clip(
		input logic signed [DW-1:0] v,
		input logic signed [DW-1:0] lo,
		input logic signed [DW-1:0] hi
	);
		logic signed [DW-1:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic valid_s14, valid_s15, valid_s16, valid_s17;
	logic ready_s14, ready_s15, ready_s16, ready_s17;

	logic [W_W-1:0] w_s14, w_s15, w_s16, weight_s17;
	logic chroma_s14, chroma_s15, chroma_s16;
	logic [DC_W-1:0] cur_dc_s14, ref_dc_s14, cur_dc_s15;
	logic [PROD_W-1:0] prod_s15;
	logic signed [PW-1:0] pred_s15, pred_s16;
	logic inr_s15, inr_s16, inr_s17;
	logic signed [TW-1:0] ofs_raw_s16;
	logic signed [OFS_W-1:0] offset_s17;

	logic [W_W-1:0] w_c;
	logic [SCL_W-1:0] scaled_c;
	logic [W_W+1:0] dw_c;
	logic [W_W-1:0] def_w_c;
	logic [SH_W-1:0] sh_c;
	logic [TW-1:0] rnd_c, t_c;
	logic signed [DW-1:0] diff_c, delta_c, sum_c, ofs_c;

	assign ready_s17 = !valid_s17 || est.ready;
	assign ready_s16 = !valid_s16 || ready_s17;
	assign ready_s15 = !valid_s15 || ready_s16;
	assign ready_s14 = !valid_s14 || ready_s15;
	assign up_ready = ready_s14;

	always_comb begin
		def_w_c = W_W'(1) << log2_denom;
		if (up.data.zero) begin
			w_c = def_w_c;
		end else if (up.data.sat) begin
			w_c = W_W'(SAT_RATIO) << log2_denom;
		end else begin
			w_c = up.data.quo;
		end

		scaled_c = {w_s14, 7'b0000000} >> log2_denom;
		dw_c = (W_W+2)'(def_w_c) - (W_W+2)'(w_s14);

		sh_c = SH_W'(log2_denom) + SH_W'(PIXEL_BITS - 8);
		rnd_c = (sh_c == '0) ? '0 : (TW'(1) << (sh_c - SH_W'(1)));
		t_c = (TW'(cur_dc_s15) << log2_denom) - TW'(prod_s15) + rnd_c;

		diff_c = DW'(ofs_raw_s16) - DW'(pred_s16);
		delta_c = clip(diff_c, DW'(DELTA_MIN), DW'(DELTA_MAX));
		sum_c = delta_c + DW'(pred_s16);
		if (chroma_s16) begin
			ofs_c = clip(sum_c, DW'(OFS_MIN), DW'(OFS_MAX));
		end else begin
			ofs_c = clip(DW'(ofs_raw_s16), DW'(OFS_MIN), DW'(OFS_MAX));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s14 <= 1'b0;
			valid_s15 <= 1'b0;
			valid_s16 <= 1'b0;
			valid_s17 <= 1'b0;
		end else begin
			if (ready_s14) begin
				valid_s14 <= up.valid;
			end
			if (ready_s15) begin
				valid_s15 <= valid_s14;
			end
			if (ready_s16) begin
				valid_s16 <= valid_s15;
			end
			if (ready_s17) begin
				valid_s17 <= valid_s16;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s14 && up.valid) begin
			w_s14 <= w_c;
			chroma_s14 <= up.data.is_chroma;
			cur_dc_s14 <= up.data.cur_dc;
			ref_dc_s14 <= up.data.ref_dc;
		end
		if (ready_s15 && valid_s14) begin
			w_s15 <= w_s14;
			chroma_s15 <= chroma_s14;
			cur_dc_s15 <= cur_dc_s14;
			prod_s15 <= PROD_W'(w_s14) * PROD_W'(ref_dc_s14);
			pred_s15 <= $signed(PW'(PRED_BASE) - PW'(scaled_c));
			inr_s15 <= ($signed(dw_c) <= WD_MAX) && ($signed(dw_c) >= WD_MIN);
		end
		if (ready_s16 && valid_s15) begin
			w_s16 <= w_s15;
			chroma_s16 <= chroma_s15;
			pred_s16 <= pred_s15;
			inr_s16 <= inr_s15;
			// arithmetic shift gives the floor
			ofs_raw_s16 <= $signed(t_c) >>> sh_c;
		end
		if (ready_s17 && valid_s16) begin
			weight_s17 <= w_s16;
			offset_s17 <= OFS_W'(ofs_c);
			inr_s17 <= inr_s16;
		end
	end

	assign est.valid = valid_s17;
	assign est.weight = weight_s17;
	assign est.offset = offset_s17;
	assign est.weight_in_range = inr_s17;

endmodule

// ===== src/wppe_checker.sv =====
`timescale 1ns / 1ps
module wppe_checker import wppe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic stat_valid,
	input logic stat_ready,
	input logic est_valid,
	input logic est_ready,
	input logic [W_W-1:0] weight,
	input logic [OFS_W-1:0] offset,
	input logic weight_in_range,
	input logic log2_denom_we,
	input logic [D_W-1:0] log2_denom_wdata
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

	logic [CNT_W-1:0] pend_q;
	logic [D_W-1:0] denom_q;
	logic [W_W+1:0] def_w;
	logic [W_W+1:0] dw;
	logic exp_inr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			denom_q <= LOG2_DENOM_RST;
		end else begin
			pend_q <= pend_q + CNT_W'(stat_valid && stat_ready) - CNT_W'(est_valid && est_ready);
			if (log2_denom_we) begin
				denom_q <= log2_denom_wdata;
			end
		end
	end

	always_comb begin
		def_w = (W_W+2)'(1) << denom_q;
		dw = def_w - (W_W+2)'(weight);
		exp_inr = ($signed(dw) <= WD_MAX) && ($signed(dw) >= WD_MIN);
	end

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid |-> pend_q != '0)
		else $error("result with no request in flight");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid |-> (weight <= W_W'(W_MAX)) && (weight_in_range == exp_inr))
		else $error("weight or range flag inconsistent");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid && !est_ready |=> est_valid && $stable(weight) && $stable(offset)
			&& $stable(weight_in_range))
		else $error("stalled result changed");

endmodule

bind weighted_pred_param_estimate wppe_checker u_wppe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.stat_valid(stat.valid),
	.stat_ready(stat.ready),
	.est_valid(est.valid),
	.est_ready(est.ready),
	.weight(est.weight),
	.offset(est.offset),
	.weight_in_range(est.weight_in_range),
	.log2_denom_we(log2_denom_we),
	.log2_denom_wdata(log2_denom_wdata)
);
